/* sv/radar_to_camera_projection_macros.svh */
// ----------------------------------------------------------------------------
// Radar to camera projection assertion macros
// Concurrent assertion helpers on clk with rst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef RADAR_TO_CAMERA_PROJECTION_MACROS_SVH
`define RADAR_TO_CAMERA_PROJECTION_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RCP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCP_ASSERT_IMPLY(lbl, ante, cons, msg)
`define RCP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/rcp_pkg.sv */
// ----------------------------------------------------------------------------
// Radar to camera projection package
// Widths, codes, bundle types and helpers shared by the projection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int HEIGHT_W    = VALUE_WIDTH - 1;
    localparam int M2_W        = VALUE_WIDTH + 1;
    localparam int SUM_W       = 2 * VALUE_WIDTH + 2;
    localparam int MAG_W       = 2 * VALUE_WIDTH + 1;
    localparam int DHC_W       = 2 * VALUE_WIDTH;
    localparam int MUL_W       = 4 * VALUE_WIDTH + 4;
    localparam int MUL_DIG     = 4;
    localparam int MUL_STAGES  = MUL_W / MUL_DIG;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int FIT_W       = 2 * MUL_W + 2;
    localparam int ROOT_BITS   = VALUE_WIDTH - 1;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CFG  = 2'd1,
        ST_DEN_ZERO = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RADAR_HEIGHT  = 2'd0,
        REG_CAMERA_HEIGHT = 2'd1,
        REG_STRIP_NEAR    = 2'd2,
        REG_STRIP_FAR     = 2'd3
    } cfg_index_t;

    localparam logic [HEIGHT_W-1:0]    RADAR_HEIGHT_RST  = HEIGHT_W'(327680);
    localparam logic [HEIGHT_W-1:0]    CAMERA_HEIGHT_RST = HEIGHT_W'(327680);
    localparam logic [VALUE_WIDTH-1:0] STRIP_NEAR_RST    = VALUE_WIDTH'(1966080);
    localparam logic [VALUE_WIDTH-1:0] STRIP_FAR_RST     = VALUE_WIDTH'(5898240);

    typedef struct packed {
        logic [HEIGHT_W-1:0]    hr;
        logic [HEIGHT_W-1:0]    hc;
        logic [VALUE_WIDTH-1:0] near;
        logic [VALUE_WIDTH-1:0] far;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic              den_neg;
        logic              prod_neg;
        logic [DHC_W-1:0]  dhc;
        logic [MAG_W-1:0]  den_mag;
        logic [MAG_W-1:0]  k_mag;
        logic [MAG_W-1:0]  num_mag;
        logic [SUM_W-1:0]  q;
    } front_out_t;

    typedef struct packed {
        status_t          status;
        logic             den_neg;
        logic             prod_neg;
        logic [SUM_W-1:0] q;
    } mid_side_t;

    typedef struct packed {
        status_t status;
        logic    neg;
    } root_side_t;

    typedef struct packed {
        logic                   valid;
        status_t                status;
        logic [VALUE_WIDTH-1:0] value;
    } root_out_t;

    // multiplicand times one narrow digit as shifted adds
    function automatic logic [MUL_W+MUL_DIG-1:0] mul_digit(
        input logic [MUL_W-1:0]   a,
        input logic [MUL_DIG-1:0] dig
    );
        logic [MUL_W+MUL_DIG-1:0] acc;
        acc = '0;
        for (int i = 0; i < MUL_DIG; i++)
        begin
            if (dig[i])
            begin
                acc = acc + ((MUL_W + MUL_DIG)'(a) << i);
            end
        end
        return acc;
    endfunction

endpackage

/* sv/rcp_mul.sv */
// ----------------------------------------------------------------------------
// Pipelined wide multiplier
// Unsigned product, one multiplier digit folded into the sum per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcp_mul
    import rcp_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] product
);

    logic [MUL_W-1:0]  a_reg    [MUL_STAGES-1];
    logic [MUL_W-1:0]  b_reg    [MUL_STAGES-1];
    logic [PROD_W-1:0] acc_reg  [MUL_STAGES];
    logic [PROD_W-1:0] acc_next [MUL_STAGES];

    always_comb
    begin
        acc_next[0] = PROD_W'(mul_digit(a, b[MUL_DIG-1:0]));
    end

    generate
        for (genvar s = 1; s < MUL_STAGES; s++)
        begin : g_acc
            always_comb
            begin
                acc_next[s] = acc_reg[s-1]
                    + (PROD_W'(mul_digit(a_reg[s-1], b_reg[s-1][s*MUL_DIG +: MUL_DIG]))
                       << (s * MUL_DIG));
            end
        end

        for (genvar s = 0; s < MUL_STAGES; s++)
        begin : g_stage
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    acc_reg[s] <= acc_next[s];
                end
            end
        end

        for (genvar s = 0; s < MUL_STAGES - 1; s++)
        begin : g_oper
            if (s == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        a_reg[s] <= a;
                        b_reg[s] <= b;
                    end
                end
            end
            else
            begin : g_rest
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        a_reg[s] <= a_reg[s-1];
                        b_reg[s] <= b_reg[s-1];
                    end
                end
            end
        end
    endgenerate

    assign product = acc_reg[MUL_STAGES-1];

endmodule

/* sv/rcp_front.sv */
// ----------------------------------------------------------------------------
// Projection front end
// Narrow products, first-order sums, magnitudes and status over three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcp_front
    import rcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [VALUE_WIDTH-1:0] target_distance,
    input  cfg_t                   cfg,
    output front_out_t             out
);

    localparam int V = VALUE_WIDTH;

    logic signed [M2_W-1:0] near_s, far_s, m2, dlen;
    logic signed [V-1:0]    hr_s, hc_s, x_s, near_v;
    logic                   bad;

    assign near_s = $signed({cfg.near[V-1], cfg.near});
    assign far_s  = $signed({cfg.far[V-1], cfg.far});
    assign m2     = near_s + far_s;
    assign dlen   = far_s - near_s;
    assign hr_s   = $signed({1'b0, cfg.hr});
    assign hc_s   = $signed({1'b0, cfg.hc});
    assign x_s    = $signed(target_distance);
    assign near_v = $signed(cfg.near);
    assign bad    = (cfg.hr == '0) || (cfg.hc == '0) || ($signed(cfg.near) >= $signed(cfg.far));

    // stage 1: narrow products
    logic signed [2*V:0]   m2hr_next, m2x_next, m2n_next;
    logic signed [2*V-1:0] xhc_next;
    logic signed [2*V+1:0] m2m2_next;
    logic [2*V-3:0]        hchr_next, hchc_next;
    logic [DHC_W-1:0]      dhc_next;

    logic signed [2*V:0]   m2hr_reg, m2x_reg, m2n_reg;
    logic signed [2*V-1:0] xhc_reg;
    logic signed [2*V+1:0] m2m2_reg;
    logic [2*V-3:0]        hchr_reg, hchc_reg;
    logic [DHC_W-1:0]      dhc1_reg;
    logic                  v1_reg, bad1_reg;

    assign m2hr_next = m2 * hr_s;
    assign xhc_next  = x_s * hc_s;
    assign hchr_next = cfg.hr * cfg.hc;
    assign m2x_next  = m2 * x_s;
    assign hchc_next = cfg.hc * cfg.hc;
    assign m2n_next  = m2 * near_v;
    assign m2m2_next = m2 * m2;
    assign dhc_next  = $unsigned(dlen) * cfg.hc;

    // stage 2: sums
    logic signed [SUM_W-1:0] num_next, den_next, k_next;
    logic [SUM_W-1:0]        q_next;
    logic signed [SUM_W-1:0] num_reg, den_reg, k_reg;
    logic [SUM_W-1:0]        q2_reg;
    logic [DHC_W-1:0]        dhc2_reg;
    logic                    v2_reg, bad2_reg;

    assign num_next = SUM_W'(m2hr_reg) - (SUM_W'(xhc_reg) <<< 1);
    assign den_next = (SUM_W'(hchr_reg) << 1) + SUM_W'(m2x_reg);
    assign k_next   = (SUM_W'(hchc_reg) << 1) + SUM_W'(m2n_reg);
    assign q_next   = (SUM_W'(hchc_reg) << 2) + SUM_W'(m2m2_reg);

    // stage 3: magnitudes and status
    logic [SUM_W-1:0] den_abs, k_abs, num_abs;
    status_t          status_next;
    logic             v3_reg;
    status_t          status3_reg;
    logic             den_neg3_reg, prod_neg3_reg;
    logic [DHC_W-1:0] dhc3_reg;
    logic [MAG_W-1:0] den_mag3_reg, k_mag3_reg, num_mag3_reg;
    logic [SUM_W-1:0] q3_reg;

    assign den_abs = den_reg[SUM_W-1] ? -den_reg : den_reg;
    assign k_abs   = k_reg[SUM_W-1]   ? -k_reg   : k_reg;
    assign num_abs = num_reg[SUM_W-1] ? -num_reg : num_reg;

    always_comb
    begin
        if (bad2_reg)
        begin
            status_next = ST_BAD_CFG;
        end
        else if (den_reg == '0)
        begin
            status_next = ST_DEN_ZERO;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2hr_reg      <= m2hr_next;
            xhc_reg       <= xhc_next;
            hchr_reg      <= hchr_next;
            m2x_reg       <= m2x_next;
            hchc_reg      <= hchc_next;
            m2n_reg       <= m2n_next;
            m2m2_reg      <= m2m2_next;
            dhc1_reg      <= dhc_next;
            bad1_reg      <= bad;

            num_reg       <= num_next;
            den_reg       <= den_next;
            k_reg         <= k_next;
            q2_reg        <= q_next;
            dhc2_reg      <= dhc1_reg;
            bad2_reg      <= bad1_reg;

            status3_reg   <= status_next;
            den_neg3_reg  <= den_reg[SUM_W-1];
            prod_neg3_reg <= k_reg[SUM_W-1] ^ num_reg[SUM_W-1];
            dhc3_reg      <= dhc2_reg;
            den_mag3_reg  <= den_abs[MAG_W-1:0];
            k_mag3_reg    <= k_abs[MAG_W-1:0];
            num_mag3_reg  <= num_abs[MAG_W-1:0];
            q3_reg        <= q2_reg;
        end
    end

    always_comb
    begin
        out.valid    = v3_reg;
        out.status   = status3_reg;
        out.den_neg  = den_neg3_reg;
        out.prod_neg = prod_neg3_reg;
        out.dhc      = dhc3_reg;
        out.den_mag  = den_mag3_reg;
        out.k_mag    = k_mag3_reg;
        out.num_mag  = num_mag3_reg;
        out.q        = q3_reg;
    end

endmodule

/* sv/rcp_root.sv */
// ----------------------------------------------------------------------------
// Projection quotient search
// Largest t with t*t*C <= A2, one result bit per stage, plus saturation test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcp_root
    import rcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  root_side_t        side,
    input  logic [PROD_W-1:0] a2,
    input  logic [PROD_W-1:0] c,
    output root_out_t         out
);

    localparam logic [VALUE_WIDTH-1:0] CAP_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] CAP_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // entry stage: scaled cap square
    logic [FIT_W-1:0] cw, capc_next;
    logic             v0_reg;
    root_side_t       side0_reg;
    logic [FIT_W-1:0] a20_reg, c0_reg, capc0_reg;

    assign cw = FIT_W'(c);

    always_comb
    begin
        if (side.neg)
        begin
            capc_next = cw << (2 * ROOT_BITS);
        end
        else
        begin
            capc_next = (cw << (2 * ROOT_BITS)) - (cw << VALUE_WIDTH) + cw;
        end
    end

    logic                 vb_reg   [ROOT_BITS+1];
    root_side_t           sb_reg   [ROOT_BITS+1];
    logic                 sat_reg  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] t_reg    [ROOT_BITS+1];
    logic [FIT_W-1:0]     rem_reg  [ROOT_BITS];
    logic [FIT_W-1:0]     u_reg    [ROOT_BITS];
    logic [FIT_W-1:0]     cb_reg   [ROOT_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            vb_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            vb_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side0_reg  <= side;
            a20_reg    <= FIT_W'(a2);
            c0_reg     <= cw;
            capc0_reg  <= capc_next;

            sb_reg[0]  <= side0_reg;
            sat_reg[0] <= (capc0_reg <= a20_reg);
            t_reg[0]   <= '0;
            rem_reg[0] <= a20_reg;
            u_reg[0]   <= '0;
            cb_reg[0]  <= c0_reg;
        end
    end

    generate
        for (genvar j = 0; j < ROOT_BITS; j++)
        begin : g_bit
            localparam int K = ROOT_BITS - 1 - j;

            logic [FIT_W-1:0]     sub;
            logic [FIT_W:0]       diff;
            logic                 take;
            logic [ROOT_BITS-1:0] t_next;

            assign sub    = (u_reg[j] << (K + 1)) + (cb_reg[j] << (2 * K));
            assign diff   = {1'b0, rem_reg[j]} - {1'b0, sub};
            assign take   = !diff[FIT_W];
            assign t_next = t_reg[j] | (ROOT_BITS'(take) << K);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vb_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    vb_reg[j+1] <= vb_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sb_reg[j+1]  <= sb_reg[j];
                    sat_reg[j+1] <= sat_reg[j];
                    t_reg[j+1]   <= t_next;
                end
            end

            if (j < ROOT_BITS - 1)
            begin : g_carry
                logic [FIT_W-1:0] rem_next, u_next;

                assign rem_next = take ? diff[FIT_W-1:0] : rem_reg[j];
                assign u_next   = take ? (u_reg[j] + (cb_reg[j] << K)) : u_reg[j];

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[j+1] <= rem_next;
                        u_reg[j+1]   <= u_next;
                        cb_reg[j+1]  <= cb_reg[j];
                    end
                end
            end
        end
    endgenerate

    logic [VALUE_WIDTH-1:0] mag;
    root_side_t             last;

    assign last = sb_reg[ROOT_BITS];

    always_comb
    begin
        if (sat_reg[ROOT_BITS])
        begin
            mag = last.neg ? CAP_NEG : CAP_POS;
        end
        else
        begin
            mag = {1'b0, t_reg[ROOT_BITS]};
        end
        out.valid  = vb_reg[ROOT_BITS];
        out.status = last.status;
        if (last.status != ST_OK)
        begin
            out.value = '0;
        end
        else
        begin
            out.value = last.neg ? -mag : mag;
        end
    end

endmodule

/* sv/radar_to_camera_projection.sv */
// Radar to camera projection.
// Input stream s_axis_*: one radar target distance per request (signed Q15.16).
// Output stream m_axis_*: one projected strip position per input, in order,
// with a status code in tuser (ok, invalid configuration, zero denominator).
// Configuration: cfg_we / cfg_index / cfg_data write radar height, camera
// height, strip near and strip far edge; write them only while idle.
// Pipeline from input accept to output valid: 3 front stages, two 33-stage
// multiplier banks, 3 combine stages, 33 search stages and the output
// register. Throughput: one request per cycle while the receiver does not stall.
// The multiplier banks fold one 4-bit digit per stage; the quotient search
// resolves one result bit per stage.
// Reset clears all valid bits and loads the default configuration
// (heights 5.0, strip 30.0 to 90.0).
// When the receiver stalls, the output register holds its request and the
// pipeline keeps advancing into empty slots; once the last stage holds a
// request it freezes and s_axis_tready drops.
// ----------------------------------------------------------------------------
// Radar to camera projection top level
// Configuration registers, multiplier banks, combine stages and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radar_to_camera_projection_macros.svh"

module radar_to_camera_projection
    import rcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [VALUE_WIDTH-1:0] s_axis_tdata,   // [31:0] target_distance
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [VALUE_WIDTH-1:0] m_axis_tdata,   // [31:0] projected_position
    output logic [1:0]             m_axis_tuser,   // [1:0] status
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0] cfg_data
);

    // configuration
    logic [HEIGHT_W-1:0]    radar_height_reg, camera_height_reg;
    logic [VALUE_WIDTH-1:0] strip_near_reg, strip_far_reg;
    cfg_t                   cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radar_height_reg  <= RADAR_HEIGHT_RST;
            camera_height_reg <= CAMERA_HEIGHT_RST;
            strip_near_reg    <= STRIP_NEAR_RST;
            strip_far_reg     <= STRIP_FAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_RADAR_HEIGHT:  radar_height_reg  <= cfg_data[HEIGHT_W-1:0];
                REG_CAMERA_HEIGHT: camera_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_STRIP_NEAR:    strip_near_reg    <= cfg_data;
                REG_STRIP_FAR:     strip_far_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.hr   = radar_height_reg;
    assign cfg.hc   = camera_height_reg;
    assign cfg.near = strip_near_reg;
    assign cfg.far  = strip_far_reg;

    // pipeline advance
    logic      en;
    root_out_t root_out;
    logic      m_valid_reg;
    logic [VALUE_WIDTH-1:0] m_data_reg;
    status_t   m_status_reg;

    assign en            = !root_out.valid || !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // front end
    front_out_t front;

    rcp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_axis_tvalid),
        .target_distance (s_axis_tdata),
        .cfg             (cfg),
        .out             (front)
    );

    // first multiplier bank
    logic [PROD_W-1:0] p1_prod, p2_prod, b2_prod;

    rcp_mul u_mul_p1 (
        .clk     (clk),
        .en      (en),
        .a       (MUL_W'(front.dhc)),
        .b       (MUL_W'(front.den_mag)),
        .product (p1_prod)
    );

    rcp_mul u_mul_p2 (
        .clk     (clk),
        .en      (en),
        .a       (MUL_W'(front.k_mag)),
        .b       (MUL_W'(front.num_mag)),
        .product (p2_prod)
    );

    rcp_mul u_mul_b2 (
        .clk     (clk),
        .en      (en),
        .a       (MUL_W'(front.den_mag)),
        .b       (MUL_W'(front.den_mag)),
        .product (b2_prod)
    );

    // side data alongside the first bank
    logic      vd1_reg [MUL_STAGES];
    mid_side_t sd1_reg [MUL_STAGES];
    mid_side_t front_side;

    assign front_side.status   = front.status;
    assign front_side.den_neg  = front.den_neg;
    assign front_side.prod_neg = front.prod_neg;
    assign front_side.q        = front.q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MUL_STAGES; i++)
            begin
                vd1_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vd1_reg[0] <= front.valid;
            for (int i = 1; i < MUL_STAGES; i++)
            begin
                vd1_reg[i] <= vd1_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd1_reg[0] <= front_side;
            for (int i = 1; i < MUL_STAGES; i++)
            begin
                sd1_reg[i] <= sd1_reg[i-1];
            end
        end
    end

    // combine stages: signed terms, difference, magnitude
    mid_side_t side1;
    logic signed [MUL_W+1:0] p1_s, p2_s, t1_next, t2_next, p_next, p_abs;

    assign side1   = sd1_reg[MUL_STAGES-1];
    assign p1_s    = $signed({2'b00, p1_prod[MUL_W-1:0]});
    assign p2_s    = $signed({2'b00, p2_prod[MUL_W-1:0]});
    assign t1_next = side1.den_neg  ? -p1_s : p1_s;
    assign t2_next = side1.prod_neg ? p2_s  : -p2_s;

    logic                    vm1_reg, vm2_reg, vm3_reg;
    mid_side_t               sm1_reg, sm2_reg;
    logic signed [MUL_W+1:0] t1_reg, t2_reg, p_reg;
    logic [MUL_W-1:0]        b2m1_reg, b2m2_reg, b2m3_reg;
    logic [MUL_W-1:0]        a3_reg, q3_reg;
    root_side_t              sm3_reg;

    assign p_next = t1_reg + t2_reg;
    assign p_abs  = p_reg[MUL_W+1] ? -p_reg : p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vm3_reg <= 1'b0;
        end
        else if (en)
        begin
            vm1_reg <= vd1_reg[MUL_STAGES-1];
            vm2_reg <= vm1_reg;
            vm3_reg <= vm2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg         <= t1_next;
            t2_reg         <= t2_next;
            b2m1_reg       <= b2_prod[MUL_W-1:0];
            sm1_reg        <= side1;

            p_reg          <= p_next;
            b2m2_reg       <= b2m1_reg;
            sm2_reg        <= sm1_reg;

            a3_reg         <= p_abs[MUL_W-1:0];
            b2m3_reg       <= b2m2_reg;
            q3_reg         <= MUL_W'(sm2_reg.q);
            sm3_reg.status <= sm2_reg.status;
            sm3_reg.neg    <= p_reg[MUL_W+1] ^ sm2_reg.den_neg;
        end
    end

    // second multiplier bank
    logic [PROD_W-1:0] a2_prod, c_prod;

    rcp_mul u_mul_a2 (
        .clk     (clk),
        .en      (en),
        .a       (a3_reg),
        .b       (a3_reg),
        .product (a2_prod)
    );

    rcp_mul u_mul_c (
        .clk     (clk),
        .en      (en),
        .a       (b2m3_reg),
        .b       (q3_reg),
        .product (c_prod)
    );

    logic       vd2_reg [MUL_STAGES];
    root_side_t sd2_reg [MUL_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MUL_STAGES; i++)
            begin
                vd2_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vd2_reg[0] <= vm3_reg;
            for (int i = 1; i < MUL_STAGES; i++)
            begin
                vd2_reg[i] <= vd2_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd2_reg[0] <= sm3_reg;
            for (int i = 1; i < MUL_STAGES; i++)
            begin
                sd2_reg[i] <= sd2_reg[i-1];
            end
        end
    end

    // quotient search
    rcp_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vd2_reg[MUL_STAGES-1]),
        .side     (sd2_reg[MUL_STAGES-1]),
        .a2       (a2_prod),
        .c        (c_prod),
        .out      (root_out)
    );

    // output register: load when empty or taken, hold otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (!m_valid_reg || m_axis_tready)
        begin
            m_valid_reg <= root_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!m_valid_reg || m_axis_tready)
        begin
            m_data_reg   <= root_out.value;
            m_status_reg <= root_out.status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_status_reg;

    `RCP_ASSERT_IMPLY(a_ready_only_on_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input blocked without an output stall")
    `RCP_ASSERT_IMPLY(a_fault_gives_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "faulted request carries nonzero position")
    `RCP_ASSERT_NEXT(a_last_stage_holds, root_out.valid && m_axis_tvalid && !m_axis_tready, root_out.valid, "request lost from last stage during stall")

endmodule
